// ===== hw/rtl/shape_rasterizer_bitmap_unit_macros.svh =====
`ifndef SHAPE_RASTERIZER_BITMAP_UNIT_MACROS_SVH
`define SHAPE_RASTERIZER_BITMAP_UNIT_MACROS_SVH

// same-cycle implication
`define SRB_ASSERT_IMP(lbl, clk, rst_n, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// next-cycle implication
`define SRB_ASSERT_NXT(lbl, clk, rst_n, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

// ===== hw/rtl/srb_pkg.sv =====
package srb_pkg;

  localparam int IN_W  = 88;
  localparam int OUT_W = 8;
  localparam int VW    = 12;  // vertex field width
  localparam int RADW  = 11;
  localparam int PTW   = 14;  // plot point, signed
  localparam int CW    = 13;  // circle x/y, signed
  localparam int ERRW  = 16;
  localparam int CDW   = 16;
  localparam int IDXW  = 10;  // row/col index inside canvas
  localparam int MULW  = 21;

  typedef enum logic [2:0] {
    CMD_CLEAR = 3'd0,
    CMD_LINE  = 3'd1,
    CMD_RECT  = 3'd2,
    CMD_CIRC  = 3'd3,
    CMD_TRI   = 3'd4,
    CMD_READ  = 3'd5
  } srb_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_LINE_INIT,
    ST_LINE_RUN,
    ST_RECT_H,
    ST_RECT_V,
    ST_CIRC,
    ST_READ,
    ST_DONE
  } srb_state_e;

  typedef struct packed {
    logic clr_start;
    logic wr_en;
    logic rd_en;
  } cv_ctrl_t;

endpackage

// ===== hw/rtl/shape_rasterizer_bitmap_unit.sv =====
// One-bit canvas rasterizer, CANVAS_ROWS x CANVAS_COLS pixels.
// Slave stream: one command per transfer (clear, line, rectangle, circle,
// triangle, pixel read). Master stream: exactly one result per command,
// pixel value and in-canvas flag for reads, zeros otherwise.
// Commands run one at a time; tready is low while a command is in work.
// Shapes are walked by one sequencer that emits one pixel per cycle through
// a single address unit (row * CANVAS_COLS + col) into a one-bit memory.
// Per command: a line or each triangle edge is set up, then walked; a
// rectangle walks its top and bottom rows, then its side columns, a
// reversed axis adding no pixels; a circle plots eight octant points per
// midpoint step; clear sweeps the whole canvas to zero.
// After reset the canvas is swept to zero; tready stays low meanwhile.
// A finished result sits in the output register; if the receiver stalls, the
// block holds in its final state until the output register is free, and
// takes no new command until then.
module shape_rasterizer_bitmap_unit #(
  parameter int CANVAS_ROWS = 50,
  parameter int CANVAS_COLS = 80
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // func[2:0], row_a, col_a, row_b, col_b, row_c, col_c, circle_radius[85:75]
  input  logic [srb_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // pixel_value[0], inside_canvas[1], zero pad
  output logic [srb_pkg::OUT_W-1:0] m_axis_tdata
);
  import srb_pkg::*;

  localparam int NPIX = CANVAS_ROWS * CANVAS_COLS;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;

  srb_state_e state_q, state_d;

  logic [2:0]            func_q, func_d;
  logic signed [PTW-1:0] va_r_q, va_c_q, vb_r_q, vb_c_q, vc_r_q, vc_c_q;
  logic signed [PTW-1:0] va_r_d, va_c_d, vb_r_d, vb_c_d, vc_r_d, vc_c_d;
  logic [1:0]            seg_q, seg_d;
  logic signed [PTW-1:0] cur_r_q, cur_c_q, end_r_q, end_c_q;
  logic signed [PTW-1:0] cur_r_d, cur_c_d, end_r_d, end_c_d;
  logic signed [ERRW-1:0] dr_q, dc_q, err_q, dr_d, dc_d, err_d;
  logic                  sr_q, sc_q, sr_d, sc_d;
  logic signed [PTW-1:0] idx_q, idx_d;
  logic                  sub_q, sub_d;
  logic signed [CW-1:0]  cx_q, cy_q, cx_d, cy_d;
  logic signed [CDW-1:0] cd_q, cd_d;
  logic [2:0]            oct_q, oct_d;

  logic          pl_vld_q, pl_vld_d;
  logic [AW-1:0] pl_addr_q;
  logic          m_valid_q, m_valid_d;
  logic [1:0]    m_data_q, m_data_d;

  logic                  accept, rsp_load, plot_en;
  logic signed [PTW-1:0] plot_r, plot_c, a_r, a_c;
  logic [MULW-1:0]       addr_full;
  logic [AW-1:0]         addr;
  cv_ctrl_t              cv_ctrl;
  logic                  cv_busy, cv_rd_data;

  logic line_at_end, rect_h_end, rect_v_end, circ_end, read_inside;
  logic signed [ERRW-1:0] diff_r, diff_c, adr, adc, err_n;
  logic signed [ERRW:0]   e2;
  logic signed [PTW-1:0]  cu, cv;

  function automatic logic on_cv(input logic signed [PTW-1:0] r,
                                 input logic signed [PTW-1:0] c);
    return (r >= $signed(PTW'(0))) && (r < $signed(PTW'(CANVAS_ROWS))) &&
           (c >= $signed(PTW'(0))) && (c < $signed(PTW'(CANVAS_COLS)));
  endfunction

  assign accept      = s_axis_tvalid && s_axis_tready;
  assign line_at_end = (cur_r_q == end_r_q) && (cur_c_q == end_c_q);
  assign rect_h_end  = idx_q > vb_c_q;
  assign rect_v_end  = idx_q > vb_r_q;
  assign circ_end    = cx_q > cy_q;
  assign read_inside = on_cv(va_r_q, va_c_q);

  // circle octant offsets
  assign cu = oct_q[2] ? PTW'(cy_q) : PTW'(cx_q);
  assign cv = oct_q[2] ? PTW'(cx_q) : PTW'(cy_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (s_axis_tdata[2:0])
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_LINE:  state_d = ST_LINE_INIT;
            CMD_TRI:   state_d = ST_LINE_INIT;
            CMD_RECT:  state_d = ST_RECT_H;
            CMD_CIRC:  state_d = ST_CIRC;
            CMD_READ:  state_d = ST_READ;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_CLEAR:     if (!cv_busy) state_d = ST_DONE;
      ST_LINE_INIT: state_d = ST_LINE_RUN;
      ST_LINE_RUN: begin
        if (line_at_end) begin
          state_d = (func_q == CMD_TRI && seg_q != 2'd2) ? ST_LINE_INIT : ST_DONE;
        end
      end
      ST_RECT_H: if (rect_h_end) state_d = ST_RECT_V;
      ST_RECT_V: if (rect_v_end) state_d = ST_DONE;
      ST_CIRC:   if (circ_end) state_d = ST_DONE;
      ST_READ:   state_d = ST_DONE;
      ST_DONE:   if (rsp_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready     = 1'b0;
    plot_en           = 1'b0;
    plot_r            = cur_r_q;
    plot_c            = cur_c_q;
    rsp_load          = 1'b0;
    cv_ctrl.clr_start = 1'b0;
    cv_ctrl.wr_en     = pl_vld_q;
    cv_ctrl.rd_en     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready     = !cv_busy;
        cv_ctrl.clr_start = accept && (s_axis_tdata[2:0] == CMD_CLEAR);
      end
      ST_LINE_RUN: plot_en = 1'b1;
      ST_RECT_H: begin
        plot_en = !rect_h_end;
        plot_r  = sub_q ? vb_r_q : va_r_q;
        plot_c  = idx_q;
      end
      ST_RECT_V: begin
        plot_en = !rect_v_end;
        plot_r  = idx_q;
        plot_c  = sub_q ? vb_c_q : va_c_q;
      end
      ST_CIRC: begin
        plot_en = !circ_end;
        plot_r  = oct_q[1] ? va_r_q - cu : va_r_q + cu;
        plot_c  = oct_q[0] ? va_c_q - cv : va_c_q + cv;
      end
      ST_READ: cv_ctrl.rd_en = 1'b1;
      ST_DONE: rsp_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // shared address unit
  assign a_r       = (state_q == ST_READ) ? va_r_q : plot_r;
  assign a_c       = (state_q == ST_READ) ? va_c_q : plot_c;
  assign addr_full = MULW'(a_r[IDXW-1:0]) * MULW'(CANVAS_COLS) + MULW'(a_c[IDXW-1:0]);
  assign addr      = addr_full[AW-1:0];

  // line setup and step terms
  assign diff_r = ERRW'(end_r_q) - ERRW'(cur_r_q);
  assign diff_c = ERRW'(end_c_q) - ERRW'(cur_c_q);
  assign adr    = diff_r[ERRW-1] ? -diff_r : diff_r;
  assign adc    = diff_c[ERRW-1] ? -diff_c : diff_c;
  assign e2     = {err_q, 1'b0};

  always_comb begin
    err_n = err_q;
    if (e2 > -(ERRW + 1)'(dc_q)) err_n = err_n - dc_q;
    if (e2 < (ERRW + 1)'(dr_q))  err_n = err_n + dr_q;
  end

  // datapath
  always_comb begin
    func_d  = func_q;
    va_r_d  = va_r_q;  va_c_d = va_c_q;
    vb_r_d  = vb_r_q;  vb_c_d = vb_c_q;
    vc_r_d  = vc_r_q;  vc_c_d = vc_c_q;
    seg_d   = seg_q;
    cur_r_d = cur_r_q; cur_c_d = cur_c_q;
    end_r_d = end_r_q; end_c_d = end_c_q;
    dr_d    = dr_q;    dc_d = dc_q;
    sr_d    = sr_q;    sc_d = sc_q;
    err_d   = err_q;
    idx_d   = idx_q;
    sub_d   = sub_q;
    cx_d    = cx_q;    cy_d = cy_q;
    cd_d    = cd_q;
    oct_d   = oct_q;
    m_data_d = m_data_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          func_d  = s_axis_tdata[2:0];
          va_r_d  = PTW'($signed(s_axis_tdata[14:3]));
          va_c_d  = PTW'($signed(s_axis_tdata[26:15]));
          vb_r_d  = PTW'($signed(s_axis_tdata[38:27]));
          vb_c_d  = PTW'($signed(s_axis_tdata[50:39]));
          vc_r_d  = PTW'($signed(s_axis_tdata[62:51]));
          vc_c_d  = PTW'($signed(s_axis_tdata[74:63]));
          cur_r_d = PTW'($signed(s_axis_tdata[14:3]));
          cur_c_d = PTW'($signed(s_axis_tdata[26:15]));
          end_r_d = PTW'($signed(s_axis_tdata[38:27]));
          end_c_d = PTW'($signed(s_axis_tdata[50:39]));
          idx_d   = PTW'($signed(s_axis_tdata[26:15]));
          seg_d   = 2'd0;
          sub_d   = 1'b0;
          oct_d   = 3'd0;
          cx_d    = '0;
          cy_d    = CW'(s_axis_tdata[85:75]);
          cd_d    = CDW'(1) - CDW'(s_axis_tdata[85:75]);
        end
      end
      ST_LINE_INIT: begin
        dr_d  = adr;
        dc_d  = adc;
        sr_d  = cur_r_q < end_r_q;
        sc_d  = cur_c_q < end_c_q;
        err_d = adr - adc;
      end
      ST_LINE_RUN: begin
        if (line_at_end) begin
          seg_d = seg_q + 2'd1;
          if (seg_q == 2'd0) begin
            cur_r_d = vb_r_q; cur_c_d = vb_c_q;
            end_r_d = vc_r_q; end_c_d = vc_c_q;
          end else begin
            cur_r_d = vc_r_q; cur_c_d = vc_c_q;
            end_r_d = va_r_q; end_c_d = va_c_q;
          end
        end else begin
          err_d = err_n;
          if (e2 > -(ERRW + 1)'(dc_q)) cur_r_d = sr_q ? cur_r_q + PTW'(1) : cur_r_q - PTW'(1);
          if (e2 < (ERRW + 1)'(dr_q))  cur_c_d = sc_q ? cur_c_q + PTW'(1) : cur_c_q - PTW'(1);
        end
      end
      ST_RECT_H: begin
        if (rect_h_end) begin
          idx_d = va_r_q;
          sub_d = 1'b0;
        end else begin
          sub_d = !sub_q;
          if (sub_q) idx_d = idx_q + PTW'(1);
        end
      end
      ST_RECT_V: begin
        if (!rect_v_end) begin
          sub_d = !sub_q;
          if (sub_q) idx_d = idx_q + PTW'(1);
        end
      end
      ST_CIRC: begin
        if (!circ_end) begin
          oct_d = oct_q + 3'd1;
          if (oct_q == 3'd7) begin
            if (cd_q < 0) begin
              cd_d = cd_q + (CDW'(cx_q) <<< 1) + CDW'(3);
            end else begin
              cd_d = cd_q + ((CDW'(cx_q) - CDW'(cy_q)) <<< 1) + CDW'(5);
              cy_d = cy_q - CW'(1);
            end
            cx_d = cx_q + CW'(1);
          end
        end
      end
      ST_DONE: begin
        if (rsp_load) begin
          m_data_d = (func_q == CMD_READ && read_inside) ? {1'b1, cv_rd_data} : 2'b00;
        end
      end
      default: ;
    endcase
  end

  assign pl_vld_d  = plot_en && on_cv(plot_r, plot_c);
  assign m_valid_d = rsp_load || (m_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pl_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pl_vld_q  <= pl_vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    va_r_q  <= va_r_d;  va_c_q <= va_c_d;
    vb_r_q  <= vb_r_d;  vb_c_q <= vb_c_d;
    vc_r_q  <= vc_r_d;  vc_c_q <= vc_c_d;
    seg_q   <= seg_d;
    cur_r_q <= cur_r_d; cur_c_q <= cur_c_d;
    end_r_q <= end_r_d; end_c_q <= end_c_d;
    dr_q    <= dr_d;    dc_q <= dc_d;
    sr_q    <= sr_d;    sc_q <= sc_d;
    err_q   <= err_d;
    idx_q   <= idx_d;
    sub_q   <= sub_d;
    cx_q    <= cx_d;    cy_q <= cy_d;
    cd_q    <= cd_d;
    oct_q   <= oct_d;
    m_data_q  <= m_data_d;
    pl_addr_q <= addr;
  end

  srb_canvas #(
    .DEPTH (NPIX),
    .AW    (AW)
  ) u_canvas (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (cv_ctrl),
    .wr_addr_i (pl_addr_q),
    .rd_addr_i (addr),
    .rd_data_o (cv_rd_data),
    .busy_o    (cv_busy)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_W - 2){1'b0}}, m_data_q};

`include "shape_rasterizer_bitmap_unit_macros.svh"

  `SRB_ASSERT_IMP(a_no_accept_in_sweep, clk_i, rst_ni, accept, !cv_busy, "command taken during sweep")
  `SRB_ASSERT_IMP(a_no_plot_in_sweep, clk_i, rst_ni, pl_vld_q, !cv_busy, "pixel write during sweep")
  `SRB_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, accept, !s_axis_tready, "ready after transfer")

endmodule

// ===== hw/rtl/srb_canvas.sv =====
module srb_canvas #(
  parameter int DEPTH = 4000,
  parameter int AW    = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  srb_pkg::cv_ctrl_t ctrl_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic             rd_data_o,
  output logic             busy_o
);
  import srb_pkg::*;

  logic          mem_q [DEPTH];
  logic          busy_q, busy_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          rd_q;

  // clear sweep: one entry per cycle, at reset and on request
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (busy_q) begin
      if (cnt_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + AW'(1);
      end
    end else if (ctrl_i.clr_start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[cnt_q] <= 1'b0;
    end else if (ctrl_i.wr_en) begin
      mem_q[wr_addr_i] <= 1'b1;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule
